### design/rgb_pixel_tone_filter_defines.svh
// Assertion macros shared by the tone filter RTL.
`ifndef RGB_PIXEL_TONE_FILTER_DEFINES_SVH
`define RGB_PIXEL_TONE_FILTER_DEFINES_SVH

`ifndef SYNTH
// Check a property on every clock edge outside reset.
`define RPTF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define RPTF_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RPTF_ASSERT(lbl, prop, msg)
`define RPTF_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### design/rptf_pkg.sv
`timescale 1ns / 1ps

package rptf_pkg;

    // Filter selection codes
    typedef enum logic [1:0] {
        MODE_BRIGHT   = 2'd0,
        MODE_CONTRAST = 2'd1,
        MODE_GRAY     = 2'd2,
        MODE_SEPIA    = 2'd3
    } rptf_mode_t;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_FILTER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_GAIN   = 1'd1;

    localparam logic [15:0] GAIN_RESET = 16'd256;

    // Gray weights folded with a reciprocal of 1000: floor(x*w/1000) is
    // exactly (x * w * GRAY_RECIP) >> GRAY_SHIFT for every 8-bit x.
    localparam int GRAY_SHIFT = 28;
    localparam int unsigned GRAY_RECIP = 268436;
    localparam int unsigned GRAY_W_BLUE = 114;
    localparam int unsigned GRAY_W_GREEN = 587;
    localparam int unsigned GRAY_W_RED = 299;

    // Sepia tint numerators over 255
    localparam logic [7:0] SEPIA_W_BLUE = 8'd145;
    localparam logic [7:0] SEPIA_W_GREEN = 8'd200;
    localparam logic [7:0] SEPIA_W_RED = 8'd240;

    localparam logic [7:0] CONTRAST_MID = 8'd128;

    typedef struct packed {
        logic [7:0] blue_in;
        logic [7:0] green_in;
        logic [7:0] red_in;
    } rptf_pix_in_t;

    typedef struct packed {
        logic [7:0] blue_out;
        logic [7:0] green_out;
        logic [7:0] red_out;
    } rptf_pix_out_t;

    typedef struct packed {
        rptf_mode_t  mode;
        logic [15:0] gain;
    } rptf_cfg_t;

    // Folded gray multiplier per channel (0 blue, 1 green, 2 red)
    function automatic logic [27:0] gray_mul(input logic [1:0] ch);
        logic [27:0] m;
        case (ch)
            2'd0: m = 28'(GRAY_W_BLUE * GRAY_RECIP);
            2'd1: m = 28'(GRAY_W_GREEN * GRAY_RECIP);
            2'd2: m = 28'(GRAY_W_RED * GRAY_RECIP);
            default: m = 28'd0;
        endcase
        return m;
    endfunction

    // Sepia tint per channel (0 blue, 1 green, 2 red)
    function automatic logic [7:0] sepia_mul(input logic [1:0] ch);
        logic [7:0] m;
        case (ch)
            2'd0: m = SEPIA_W_BLUE;
            2'd1: m = SEPIA_W_GREEN;
            2'd2: m = SEPIA_W_RED;
            default: m = 8'd0;
        endcase
        return m;
    endfunction

endpackage

### design/rptf_pipe.sv
`timescale 1ns / 1ps
`include "rgb_pixel_tone_filter_defines.svh"

module rptf_pipe
    import rptf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  rptf_cfg_t     cfg,
    input  logic          pixel_valid,
    output logic          pixel_ready,
    input  rptf_pix_in_t  pixel,
    output logic          result_valid,
    input  logic          result_ready,
    output rptf_pix_out_t result
);

    // Stage valid bits and per-stage ready
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy_out;

    // Stage 1: captured pixel
    logic [7:0] s1_pix_reg [3];
    // Stage 2: channel products and gray terms
    logic signed [25:0] s2_prod_reg [3];
    logic [7:0] s2_gterm_reg [3];
    // Stage 3: saturated channel results and gray sum
    logic [7:0] s3_chan_reg [3];
    logic [7:0] s3_gray_reg;
    // Stage 4: channel results, gained gray, sepia products
    logic [7:0] s4_chan_reg [3];
    logic [23:0] s4_gprod_reg;
    logic [15:0] s4_sep_reg [3];
    // Output register
    rptf_pix_out_t out_reg;

    logic signed [25:0] prod_next [3];
    logic [7:0] gterm_next [3];
    logic [7:0] chan_next [3];
    logic [7:0] gray_next;
    logic [23:0] gprod_next;
    logic [15:0] sep_next [3];
    rptf_pix_out_t out_next;

    logic signed [8:0] op [3];
    logic [35:0] gmul [3];
    logic signed [25:0] tsum [3];
    logic [9:0] gsum;
    logic [16:0] sep_acc [3];
    logic [7:0] sep_q [3];
    logic [7:0] gray_sat;
    logic [7:0] res [3];

    // Ready ripples back: a stage takes data when it is empty or drains
    assign rdy_out = !out_valid_reg || result_ready;
    assign rdy4 = !s4_valid_reg || rdy_out;
    assign rdy3 = !s3_valid_reg || rdy4;
    assign rdy2 = !s2_valid_reg || rdy3;
    assign rdy1 = !s1_valid_reg || rdy2;
    assign pixel_ready = rdy1;

    // Stage 1 -> 2: one gain multiplier per channel, gray terms
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.mode == MODE_CONTRAST)
            begin
                op[i] = $signed({1'b0, s1_pix_reg[i]}) - $signed({1'b0, CONTRAST_MID});
            end
            else
            begin
                op[i] = $signed({1'b0, s1_pix_reg[i]});
            end
            prod_next[i] = $signed({{17{op[i][8]}}, op[i]}) * $signed({10'd0, cfg.gain});
            gmul[i] = {28'd0, s1_pix_reg[i]} * {8'd0, gray_mul(2'(i))};
            gterm_next[i] = gmul[i][35:GRAY_SHIFT];
        end
    end

    // Stage 2 -> 3: add mid gray back for contrast, clamp, sum gray
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (cfg.mode == MODE_CONTRAST)
            begin
                tsum[i] = s2_prod_reg[i] + 26'sd32768;
            end
            else
            begin
                tsum[i] = s2_prod_reg[i];
            end
            if (tsum[i][25])
            begin
                chan_next[i] = 8'd0;
            end
            else if (|tsum[i][24:16])
            begin
                chan_next[i] = 8'd255;
            end
            else
            begin
                chan_next[i] = tsum[i][15:8];
            end
        end
        gsum = {2'd0, s2_gterm_reg[0]} + {2'd0, s2_gterm_reg[1]} + {2'd0, s2_gterm_reg[2]};
        gray_next = gsum[7:0];
    end

    // Stage 3 -> 4: gray times gain, sepia tints
    always_comb
    begin
        gprod_next = {16'd0, s3_gray_reg} * {8'd0, cfg.gain};
        for (int i = 0; i < 3; i++)
        begin
            sep_next[i] = {8'd0, s3_gray_reg} * {8'd0, sepia_mul(2'(i))};
        end
    end

    // Stage 4 -> out: divide sepia by 255, saturate gray, pick by mode
    always_comb
    begin
        gray_sat = (|s4_gprod_reg[23:16]) ? 8'd255 : s4_gprod_reg[15:8];
        for (int i = 0; i < 3; i++)
        begin
            sep_acc[i] = {1'b0, s4_sep_reg[i]} + {9'd0, s4_sep_reg[i][15:8]} + 17'd1;
            sep_q[i] = sep_acc[i][15:8];
            case (cfg.mode)
                MODE_BRIGHT, MODE_CONTRAST: res[i] = s4_chan_reg[i];
                MODE_GRAY: res[i] = gray_sat;
                MODE_SEPIA: res[i] = sep_q[i];
                default: res[i] = s4_chan_reg[i];
            endcase
        end
        out_next.blue_out = res[0];
        out_next.green_out = res[1];
        out_next.red_out = res[2];
    end

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                s1_valid_reg <= pixel_valid;
            end
            if (rdy2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (rdy3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (rdy4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (rdy_out)
            begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    // Advance payload on each transfer into a stage
    always_ff @(posedge clk)
    begin
        if (rdy1 && pixel_valid)
        begin
            s1_pix_reg[0] <= pixel.blue_in;
            s1_pix_reg[1] <= pixel.green_in;
            s1_pix_reg[2] <= pixel.red_in;
        end
        if (rdy2 && s1_valid_reg)
        begin
            s2_prod_reg <= prod_next;
            s2_gterm_reg <= gterm_next;
        end
        if (rdy3 && s2_valid_reg)
        begin
            s3_chan_reg <= chan_next;
            s3_gray_reg <= gray_next;
        end
        if (rdy4 && s3_valid_reg)
        begin
            s4_chan_reg <= s3_chan_reg;
            s4_gprod_reg <= gprod_next;
            s4_sep_reg <= sep_next;
        end
        if (rdy_out && s4_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result = out_reg;

    `RPTF_ASSERT(a_stage_advance, s3_valid_reg && rdy4 |=> s4_valid_reg,
        "stage 4 lost an item from stage 3")
    `RPTF_ASSERT(a_gray_equal,
        result_valid && cfg.mode == MODE_GRAY |->
        result.blue_out == result.green_out && result.green_out == result.red_out,
        "grayscale channels differ")
    `RPTF_ASSERT(a_sepia_order,
        result_valid && cfg.mode == MODE_SEPIA |->
        result.red_out >= result.green_out && result.green_out >= result.blue_out,
        "sepia tint order broken")
    `RPTF_ASSERT(a_contrast_zero_gain,
        result_valid && cfg.mode == MODE_CONTRAST && cfg.gain == 16'd0 |->
        result.blue_out == CONTRAST_MID && result.red_out == CONTRAST_MID,
        "zero contrast gain must give mid gray")
    `RPTF_ASSERT_ALWAYS(a_empty_ready,
        !s1_valid_reg && !s2_valid_reg && !s3_valid_reg && !s4_valid_reg |-> pixel_ready,
        "empty pipeline refuses input")

endmodule

### design/rgb_pixel_tone_filter.sv
`timescale 1ns / 1ps
// Per-pixel tone filter for 24-bit BGR pixels.
// Input channel: pixel_valid / pixel_ready with a packed pixel (blue, green,
// red); output channel: result_valid / result_ready with the filtered pixel.
// A pixel transfers on a rising edge with valid and ready both high.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 filter
// mode: brightness, contrast, grayscale, sepia; 1 gain, unsigned Q8.8).
// Write configuration only while no pixel is in flight.
// Throughput: one pixel per clock while result_ready stays high. Each pixel
// passes four arithmetic stages on its way to result_valid (gain multiply, clamp
// and gray sum, gray gain and sepia multiply, sepia divide and mode select);
// the pixel is registered on entry and the last stage ends in the output
// register.
// Reset clears all stage valid bits, sets mode to brightness and gain to 1.0.
// When the receiver holds result_ready low the result stays put, stages
// behind it fill up their bubbles, and pixel_ready drops once every stage
// is occupied; nothing is dropped or repeated.
module rgb_pixel_tone_filter
    import rptf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    output logic                  pixel_ready,
    input  rptf_pix_in_t          pixel,
    output logic                  result_valid,
    input  logic                  result_ready,
    output rptf_pix_out_t         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    rptf_mode_t  mode_reg;
    logic [15:0] gain_reg;
    rptf_cfg_t   cfg;

    // Hold configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_BRIGHT;
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FILTER_MODE: mode_reg <= rptf_mode_t'(cfg_data[1:0]);
                REG_RATE_GAIN: gain_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign cfg.mode = mode_reg;
    assign cfg.gain = gain_reg;

    rptf_pipe u_pipe (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

### dv/rgb_pixel_tone_filter_checker.sv
`timescale 1ns / 1ps

module rgb_pixel_tone_filter_checker
    import rptf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pixel_valid,
    input  logic                  pixel_ready,
    input  rptf_pix_in_t          pixel,
    input  logic                  result_valid,
    input  logic                  result_ready,
    input  rptf_pix_out_t         result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    pending,
    output int                    errors
);

    localparam longint LUMA_W_BLUE  = 114;
    localparam longint LUMA_W_GREEN = 587;
    localparam longint LUMA_W_RED   = 299;
    localparam longint LUMA_DIV     = 1000;
    localparam longint TINT_BLUE    = 145;
    localparam longint TINT_GREEN   = 200;
    localparam longint TINT_RED     = 240;
    localparam longint TINT_DIV     = 255;
    localparam longint MID_LEVEL    = 128;
    localparam int     MAX_REPORTS  = 10;

    rptf_mode_t    cur_mode;
    logic [15:0]   cur_gain;
    rptf_pix_out_t tone_fifo[$];
    int            miss_cnt;

    // Saturate a signed intermediate to one channel byte
    function automatic logic [7:0] clip8(longint v);
        if (v < 0)
            return 8'd0;
        if (v > 255)
            return 8'd255;
        return v[7:0];
    endfunction

    // Expected filtered pixel for one input pixel under the given setting
    function automatic rptf_pix_out_t tone_of(rptf_pix_in_t px, rptf_mode_t m,
                                              logic [15:0] gain);
        longint g;
        longint b;
        longint gr;
        longint r;
        longint luma;
        rptf_pix_out_t o;
        g = longint'(gain);
        b = longint'(px.blue_in);
        gr = longint'(px.green_in);
        r = longint'(px.red_in);
        luma = (b * LUMA_W_BLUE) / LUMA_DIV + (gr * LUMA_W_GREEN) / LUMA_DIV
             + (r * LUMA_W_RED) / LUMA_DIV;
        case (m)
            MODE_BRIGHT:
            begin
                o.blue_out  = clip8((b * g) >>> 8);
                o.green_out = clip8((gr * g) >>> 8);
                o.red_out   = clip8((r * g) >>> 8);
            end
            MODE_CONTRAST:
            begin
                // keep the midpoint before truncation; negative results clamp to 0
                o.blue_out  = clip8(((b - MID_LEVEL) * g + (MID_LEVEL << 8)) >>> 8);
                o.green_out = clip8(((gr - MID_LEVEL) * g + (MID_LEVEL << 8)) >>> 8);
                o.red_out   = clip8(((r - MID_LEVEL) * g + (MID_LEVEL << 8)) >>> 8);
            end
            MODE_GRAY:
            begin
                o.blue_out  = clip8((luma * g) >>> 8);
                o.green_out = o.blue_out;
                o.red_out   = o.blue_out;
            end
            default:
            begin
                o.blue_out  = clip8((luma * TINT_BLUE) / TINT_DIV);
                o.green_out = clip8((luma * TINT_GREEN) / TINT_DIV);
                o.red_out   = clip8((luma * TINT_RED) / TINT_DIV);
            end
        endcase
        return o;
    endfunction

    task automatic flag_miss(string what, rptf_pix_out_t want, rptf_pix_out_t got);
        miss_cnt++;
        if (miss_cnt <= MAX_REPORTS)
            $display("%0t: %s: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                     $time, what, want.blue_out, want.green_out, want.red_out,
                     got.blue_out, got.green_out, got.red_out);
    endtask

    // Track the settings, predict on each pixel transfer, compare on each result
    always @(posedge clk or negedge rst_n)
    begin
        rptf_pix_out_t want;
        if (!rst_n)
        begin
            cur_mode = MODE_BRIGHT;
            cur_gain = GAIN_RESET;
            tone_fifo.delete();
            miss_cnt = 0;
            pending <= 0;
            errors <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (tone_fifo.size() == 0)
                begin
                    want = '0;
                    flag_miss("unexpected result", want, result);
                end
                else
                begin
                    want = tone_fifo.pop_front();
                    if (result.blue_out !== want.blue_out
                        || result.green_out !== want.green_out
                        || result.red_out !== want.red_out)
                        flag_miss("result mismatch", want, result);
                end
            end
            if (pixel_valid && pixel_ready)
                tone_fifo.push_back(tone_of(pixel, cur_mode, cur_gain));
            // register writes take effect for later pixels
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_FILTER_MODE: cur_mode = rptf_mode_t'(cfg_data[1:0]);
                    REG_RATE_GAIN:   cur_gain = cfg_data[15:0];
                    default:         ;
                endcase
            end
            pending <= tone_fifo.size();
            errors <= miss_cnt;
        end
    end

endmodule

### dv/tb_rgb_pixel_tone_filter.sv
`timescale 1ns / 1ps

module tb_rgb_pixel_tone_filter;
    import rptf_pkg::*;

    localparam int TIMEOUT_CYCLES = 200000;
    localparam int TAIL_CYCLES    = 20;
    localparam int RANDOM_PIXELS  = 600;
    localparam int MAX_GAP        = 17;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  pixel_valid = 1'b0;
    logic                  pixel_ready;
    rptf_pix_in_t          pixel = '0;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    rptf_pix_out_t         result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_FILTER_MODE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int pending;
    int errors;
    int cycles = 0;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    rgb_pixel_tone_filter i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    rgb_pixel_tone_filter_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pending      (pending),
        .errors       (errors)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= TIMEOUT_CYCLES)
        begin
            $display("tb_rgb_pixel_tone_filter NOT OK");
            $finish;
        end
    end

    // Write gain, then mode with junk in the unused upper bits
    task automatic load_filter(rptf_mode_t m, logic [15:0] g);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        cfg_we <= 1'b1;
        cfg_index <= REG_RATE_GAIN;
        cfg_data <= g;
        @(posedge clk);
        cfg_index <= REG_FILTER_MODE;
        cfg_data <= {junk[CFG_DATA_W-1:2], m};
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Offer one pixel after a random gap and hold it until the transfer
    task automatic send_pixel(rptf_pix_in_t px);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            pixel_valid <= 1'b0;
            pixel <= rptf_pix_in_t'($urandom);
            repeat (gap) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel <= px;
        do
            @(posedge clk);
        while (!pixel_ready);
    endtask

    // Drop valid and wait until every outstanding result has come back
    task automatic drain_results();
        pixel_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // Mostly random channel values, with a bias toward the edges of the range
    function automatic logic [7:0] pick_level();
        logic [7:0] edges [5] = '{8'd0, 8'd255, 8'd127, 8'd128, 8'd129};
        if ($urandom_range(0, 3) == 0)
            return edges[$urandom_range(0, 4)];
        return 8'($urandom);
    endfunction

    // Receiver: random stall before each result, bursts with no stall
    initial
    begin
        int stall;
        forever
        begin
            stall = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_valid);
        end
    end

    // Stimulus and verdict
    initial
    begin
        rptf_pix_in_t probes [4];
        rptf_mode_t   dir_mode [6];
        logic [15:0]  dir_gain [6];
        logic [15:0]  gain_edges [7];
        rptf_mode_t   mode;
        logic [15:0]  gain;
        int           sent;
        int           len;

        probes = '{24'h000000, 24'hFFFFFF, 24'h7F8081, 24'h00FF80};
        dir_mode = '{MODE_BRIGHT, MODE_CONTRAST, MODE_CONTRAST, MODE_GRAY,
                     MODE_SEPIA, MODE_BRIGHT};
        dir_gain = '{16'd256, 16'd65535, 16'd0, 16'd0, 16'd256, 16'd65535};
        gain_edges = '{16'd0, 16'd1, 16'd255, 16'd256, 16'd257, 16'd511, 16'd65535};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset setting first, then every mode with edge gains
        for (int p = 0; p < 6; p++)
        begin
            if (p != 0)
                load_filter(dir_mode[p], dir_gain[p]);
            for (int k = 0; k < 4; k++)
                send_pixel(probes[k]);
            drain_results();
        end

        // Random phases, each under a fresh setting
        sent = 0;
        while (sent < RANDOM_PIXELS)
        begin
            mode = rptf_mode_t'($urandom_range(0, 3));
            case ($urandom_range(0, 3))
                0:       gain = gain_edges[$urandom_range(0, 6)];
                1:       gain = 16'($urandom_range(0, 65535));
                default: gain = 16'($urandom_range(0, 1023));
            endcase
            load_filter(mode, gain);
            tx_burst = ($urandom_range(0, 3) == 0);
            rx_burst <= ($urandom_range(0, 3) == 0);
            len = $urandom_range(20, 80);
            repeat (len)
            begin
                send_pixel({pick_level(), pick_level(), pick_level()});
                sent++;
                // occasionally let the pipeline run empty mid-phase
                if ($urandom_range(0, 49) == 0)
                    drain_results();
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("tb_rgb_pixel_tone_filter OK");
        else
            $display("tb_rgb_pixel_tone_filter NOT OK");
        $finish;
    end

endmodule

### files.f
+incdir+design
design/rptf_pkg.sv
design/rptf_pipe.sv
design/rgb_pixel_tone_filter.sv
dv/rgb_pixel_tone_filter_checker.sv
dv/tb_rgb_pixel_tone_filter.sv
